/* rtl/dts_pkg.sv */
package dts_pkg;

   // Default sizes of the timer table and of the internal time base.
   localparam int NUM_TIMERS_DEF = 16;
   localparam int TIME_BITS_DEF  = 48;

   // Fixed field widths of the request and response words.
   localparam int MODE_W     = 3;
   localparam int ID_W       = 5;
   localparam int MS32_W     = 32;
   localparam int MS48_W     = 48;
   localparam int KIND_W     = 2;

   // Operation codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_RUN    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_START  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STOP   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd5;

   // Response kinds.
   localparam logic [KIND_W-1:0] KIND_FIRED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd2;

   // Sequencer states of the scheduler.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ALLOC,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE
   } state_type;

endpackage

/* rtl/dts_slot_ram.sv */
module dts_slot_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 80,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/deadline_timer_scheduler.sv */
// Delete, start, stop and unknown modes: one response word, emitted from the dispatch state.
// Allocate: the allocated flags are walked for the lowest free slot, one flag tested per cycle.
// Query: one slot memory read per cycle for the minimum search.
// Run: each firing rescans the slot memory for the next due timer.
// One request is in work at a time; the next is taken the cycle after its last word issues.
// Synchronous reset clears all allocated and armed flags; slot memory needs no clearing.
module deadline_timer_scheduler #(
   parameter int NUM_TIMERS = dts_pkg::NUM_TIMERS_DEF,
   parameter int TIME_BITS  = dts_pkg::TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dts_pkg::MODE_W-1:0]   req_mode,
   input  logic [dts_pkg::ID_W-1:0]     req_timer_index,
   input  logic [dts_pkg::MS32_W-1:0]   req_delay_ms,
   input  logic [dts_pkg::MS32_W-1:0]   req_interval_ms,
   input  logic [dts_pkg::MS48_W-1:0]   req_now_ms,
   input  logic [dts_pkg::MS48_W-1:0]   req_fallback_ms,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dts_pkg::KIND_W-1:0]   rsp_kind,
   output logic [dts_pkg::ID_W-1:0]     rsp_timer_ref,
   output logic [dts_pkg::MS48_W-1:0]   rsp_fired_deadline,
   output logic [dts_pkg::MS48_W-1:0]   rsp_result_value,
   output logic                         rsp_last
);

   localparam int TB  = TIME_BITS;
   localparam int TBP = TIME_BITS + 1;
   localparam int IW  = $clog2(NUM_TIMERS);
   localparam int CW  = $clog2(NUM_TIMERS + 1);
   localparam int MW  = TIME_BITS + dts_pkg::MS32_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

   dts_pkg::state_type state_ff, state_in;

   // Latched request word.
   logic [dts_pkg::MODE_W-1:0] mode_ff;
   logic [dts_pkg::ID_W-1:0]   id_ff;
   logic [dts_pkg::MS32_W-1:0] delay_ff;
   logic [dts_pkg::MS32_W-1:0] ival_ff;
   logic [TB-1:0]              now_ff;
   logic [TB-1:0]              fb_ff;

   // Slot flags, fired set and armed count.
   logic [NUM_TIMERS-1:0] alloc_ff;
   logic [NUM_TIMERS-1:0] armed_ff;
   logic [NUM_TIMERS-1:0] fired_ff;
   logic [CW-1:0]         count_ff;

   // Scan counter, read pipeline and running minimum.
   logic [IW-1:0]              scan_idx_ff;
   logic                       rd_valid_ff;
   logic [IW-1:0]              rd_idx_ff;
   logic                       best_valid_ff;
   logic [IW-1:0]              best_idx_ff;
   logic [TB-1:0]              best_dl_ff;
   logic [dts_pkg::MS32_W-1:0] best_int_ff;

   // Response register.
   logic                       rsp_valid_ff;
   logic [dts_pkg::KIND_W-1:0] rsp_kind_ff;
   logic [dts_pkg::ID_W-1:0]   rsp_ref_ff;
   logic [dts_pkg::MS48_W-1:0] rsp_dl_ff;
   logic [dts_pkg::MS48_W-1:0] rsp_val_ff;
   logic                       rsp_last_ff;

   // Sequencer strobes.
   logic                       emit;
   logic [dts_pkg::KIND_W-1:0] e_kind;
   logic [dts_pkg::ID_W-1:0]   e_ref;
   logic [dts_pkg::MS48_W-1:0] e_dl;
   logic [dts_pkg::MS48_W-1:0] e_val;
   logic                       e_last;
   logic                       mem_we;
   logic [IW-1:0]              mem_waddr;
   logic [IW-1:0]              fl_slot;
   logic                       set_alloc, clr_alloc, set_armed, clr_armed, set_fired;
   logic                       cnt_inc, cnt_dec;
   logic                       scan_clear, idx_inc, clear_fired;

   logic                       accept;
   logic                       out_free;
   logic [IW-1:0]              id_slot;
   logic                       id_ok;
   logic [dts_pkg::MS32_W-1:0] addend;
   logic [dts_pkg::MS32_W-1:0] wr_int;
   logic [TB:0]                sum_w;
   logic [TB-1:0]              sat_sum;
   logic [MW-1:0]              rd_data;
   logic [TB-1:0]              rd_dl;
   logic [dts_pkg::MS32_W-1:0] rd_int;
   logic                       cand;
   logic                       due;
   logic [TB-1:0]              remain;

   assign req_stall = (state_ff != dts_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Timer id to slot number; ids are 1-based.
   assign id_slot = IW'(32'(id_ff) - 32'd1);
   assign id_ok   = (id_ff != '0) && (32'(id_ff) <= NUM_TIMERS) && alloc_ff[id_slot];

   // Saturating deadline adder, shared by start and periodic reload.
   assign addend  = (state_ff == dts_pkg::ST_DECIDE) ? best_int_ff : delay_ff;
   assign sum_w   = {1'b0, now_ff} + TBP'(addend);
   assign sat_sum = sum_w[TB] ? '1 : sum_w[TB-1:0];

   // Start stores the new interval; a reload keeps the stored one.
   assign wr_int  = (state_ff == dts_pkg::ST_DECIDE) ? best_int_ff : ival_ff;

   // Slot memory: interval in the upper bits, deadline in the lower bits.
   dts_slot_ram #(
      .DEPTH (NUM_TIMERS),
      .WIDTH (MW),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data ({wr_int, sat_sum}),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign rd_dl  = rd_data[TB-1:0];
   assign rd_int = rd_data[MW-1:TB];

   // An armed slot not yet fired in this run that beats the current minimum.
   assign cand = rd_valid_ff && armed_ff[rd_idx_ff] && !fired_ff[rd_idx_ff]
                 && (!best_valid_ff || (rd_dl < best_dl_ff));
   assign due    = best_valid_ff && (best_dl_ff <= now_ff);
   assign remain = best_dl_ff - now_ff;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and control strobes.
   always_comb begin
      state_in    = state_ff;
      emit        = 1'b0;
      e_kind      = dts_pkg::KIND_OK;
      e_ref       = '0;
      e_dl        = '0;
      e_val       = '0;
      e_last      = 1'b1;
      mem_we      = 1'b0;
      mem_waddr   = id_slot;
      fl_slot     = id_slot;
      set_alloc   = 1'b0;
      clr_alloc   = 1'b0;
      set_armed   = 1'b0;
      clr_armed   = 1'b0;
      set_fired   = 1'b0;
      cnt_inc     = 1'b0;
      cnt_dec     = 1'b0;
      scan_clear  = 1'b0;
      idx_inc     = 1'b0;
      clear_fired = 1'b0;
      case (state_ff)
         dts_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = dts_pkg::ST_DISPATCH;
            end
         end
         dts_pkg::ST_DISPATCH: begin
            case (mode_ff)
               dts_pkg::MODE_RUN, dts_pkg::MODE_QUERY: begin
                  scan_clear  = 1'b1;
                  clear_fired = 1'b1;
                  state_in    = dts_pkg::ST_SCAN;
               end
               dts_pkg::MODE_ALLOC: begin
                  scan_clear = 1'b1;
                  state_in   = dts_pkg::ST_ALLOC;
               end
               dts_pkg::MODE_DELETE, dts_pkg::MODE_START, dts_pkg::MODE_STOP: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     e_kind   = id_ok ? dts_pkg::KIND_OK : dts_pkg::KIND_FAIL;
                     state_in = dts_pkg::ST_IDLE;
                     if (id_ok) begin
                        if (mode_ff == dts_pkg::MODE_START) begin
                           mem_we    = 1'b1;
                           set_armed = 1'b1;
                           cnt_inc   = !armed_ff[id_slot];
                        end else begin
                           clr_armed = 1'b1;
                           cnt_dec   = armed_ff[id_slot];
                           clr_alloc = (mode_ff == dts_pkg::MODE_DELETE);
                        end
                     end
                  end
               end
               default: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     e_kind   = dts_pkg::KIND_FAIL;
                     state_in = dts_pkg::ST_IDLE;
                  end
               end
            endcase
         end
         dts_pkg::ST_ALLOC: begin
            // Walk the allocated flags for the lowest free slot.
            fl_slot = scan_idx_ff;
            if (!alloc_ff[scan_idx_ff]) begin
               if (out_free) begin
                  emit      = 1'b1;
                  e_ref     = dts_pkg::ID_W'(32'(scan_idx_ff) + 32'd1);
                  set_alloc = 1'b1;
                  clr_armed = 1'b1;
                  state_in  = dts_pkg::ST_IDLE;
               end
            end else if (scan_idx_ff == LAST_IDX) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_kind   = dts_pkg::KIND_FAIL;
                  state_in = dts_pkg::ST_IDLE;
               end
            end else begin
               idx_inc = 1'b1;
            end
         end
         dts_pkg::ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = dts_pkg::ST_SCAN_END;
            end else begin
               idx_inc = 1'b1;
            end
         end
         dts_pkg::ST_SCAN_END: begin
            state_in = dts_pkg::ST_DECIDE;
         end
         dts_pkg::ST_DECIDE: begin
            mem_waddr = best_idx_ff;
            fl_slot   = best_idx_ff;
            if (mode_ff == dts_pkg::MODE_RUN) begin
               if (due) begin
                  // Fire the earliest due timer, then rescan for the next one.
                  if (out_free) begin
                     emit       = 1'b1;
                     e_kind     = dts_pkg::KIND_FIRED;
                     e_ref      = dts_pkg::ID_W'(32'(best_idx_ff) + 32'd1);
                     e_dl       = dts_pkg::MS48_W'(best_dl_ff);
                     e_last     = 1'b0;
                     set_fired  = 1'b1;
                     scan_clear = 1'b1;
                     state_in   = dts_pkg::ST_SCAN;
                     if (best_int_ff != '0) begin
                        mem_we = 1'b1;
                     end else begin
                        clr_armed = 1'b1;
                        cnt_dec   = 1'b1;
                     end
                  end
               end else if (out_free) begin
                  emit     = 1'b1;
                  e_val    = dts_pkg::MS48_W'(count_ff);
                  state_in = dts_pkg::ST_IDLE;
               end
            end else if (out_free) begin
               emit = 1'b1;
               if (!best_valid_ff) begin
                  e_val = dts_pkg::MS48_W'(fb_ff);
               end else if (!due) begin
                  e_val = dts_pkg::MS48_W'(remain);
               end
               state_in = dts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dts_pkg::ST_IDLE;
         end
      endcase
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         id_ff    <= req_timer_index;
         delay_ff <= req_delay_ms;
         ival_ff  <= req_interval_ms;
         now_ff   <= TB'(req_now_ms);
         fb_ff    <= TB'(req_fallback_ms);
      end
   end

   // Slot flags and armed count.
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= '0;
         armed_ff <= '0;
         fired_ff <= '0;
         count_ff <= '0;
      end else begin
         if (set_alloc) begin
            alloc_ff[fl_slot] <= 1'b1;
         end
         if (clr_alloc) begin
            alloc_ff[fl_slot] <= 1'b0;
         end
         if (set_armed) begin
            armed_ff[fl_slot] <= 1'b1;
         end
         if (clr_armed) begin
            armed_ff[fl_slot] <= 1'b0;
         end
         if (clear_fired) begin
            fired_ff <= '0;
         end else if (set_fired) begin
            fired_ff[fl_slot] <= 1'b1;
         end
         if (cnt_inc) begin
            count_ff <= count_ff + CW'(1);
         end else if (cnt_dec) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   // Scan counter, read pipeline and minimum search.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         if (scan_clear) begin
            scan_idx_ff <= '0;
         end else if (idx_inc) begin
            scan_idx_ff <= scan_idx_ff + IW'(1);
         end
         rd_valid_ff <= (state_ff == dts_pkg::ST_SCAN);
         if (scan_clear) begin
            best_valid_ff <= 1'b0;
         end else if (cand) begin
            best_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_idx_ff;
      if (cand) begin
         best_idx_ff <= rd_idx_ff;
         best_dl_ff  <= rd_dl;
         best_int_ff <= rd_int;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= e_kind;
         rsp_ref_ff  <= e_ref;
         rsp_dl_ff   <= e_dl;
         rsp_val_ff  <= e_val;
         rsp_last_ff <= e_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_timer_ref      = rsp_ref_ff;
   assign rsp_fired_deadline = rsp_dl_ff;
   assign rsp_result_value   = rsp_val_ff;
   assign rsp_last           = rsp_last_ff;

endmodule
